// ----- sv/cwdm_pkg.sv -----
// Shared types and constants for the circular window distinct-max block.
`default_nettype none

package cwdm_pkg;

    // Fixed field widths of the ports
    localparam int TYPE_W    = 12;
    localparam int LEN_W     = 13;
    localparam int SCORE_W   = 13;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BONUS_TYPE = 1'd1;

    // Configuration reset values
    localparam logic [LEN_W-1:0]  WINDOW_LEN_RST = 13'd4;
    localparam logic [TYPE_W-1:0] BONUS_TYPE_RST = 12'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;     // latch the incoming item
        logic ring_rd;    // read ring at the slot and head at the replay index
        logic replay;     // entering type comes from the head store
        logic cnt_rd;     // read both count entries, write ring and head
        logic upd;        // evict old entry, update distinct, bonus and best
        logic wrx;        // write back the count of the entering type
        logic rep_init;   // start the replay of the head items
        logic rep_next;   // advance the replay index
        logic emit;       // register the result and arm the clear pass
        logic clr_step;   // one step of the count clear after a run
        logic init_step;  // one step of the count sweep after reset
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;       // current item closes the sequence
        logic too_short;  // fewer items than the window length so far
        logic no_replay;  // window length of one: nothing to replay
        logic rep_last;   // current replay slide is the final one
        logic clr_done;   // clear pass finished
        logic init_done;  // reset sweep at its final entry
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/cwdm_modred.sv -----
// Remainder of a 12-bit type code by a constant: reciprocal multiply and one correction.
`default_nettype none

module cwdm_modred #(
    parameter int DIVISOR = 4096
) (
    input  logic                                  i_clk,
    input  logic [cwdm_pkg::TYPE_W-1:0]           i_value,
    output logic [$clog2(DIVISOR)-1:0]            o_rem
);
    import cwdm_pkg::*;

    localparam int RW = $clog2(DIVISOR);
    localparam int PW = TYPE_W + 24;
    localparam int QW = 29;
    localparam logic [23:0] RECIP = 24'((1 << 24) / DIVISOR);

    logic [TYPE_W-1:0] r_val;
    logic [PW-1:0]     r_prod;
    logic [TYPE_W-1:0] quot;
    logic [QW-1:0]     qd;
    logic [QW-1:0]     rem0;
    logic [QW-1:0]     rem1;

    // Stage one: value times the scaled reciprocal
    always_ff @(posedge i_clk) begin
        r_val  <= i_value;
        r_prod <= PW'(i_value) * PW'(RECIP);
    end

    // Stage two: quotient estimate is exact or one low
    always_comb begin
        quot  = r_prod[PW-1:24];
        qd    = QW'(quot) * QW'(DIVISOR);
        rem0  = QW'(r_val) - qd;
        rem1  = (rem0 >= QW'(DIVISOR)) ? rem0 - QW'(DIVISOR) : rem0;
        o_rem = RW'(rem1);
    end

endmodule

`default_nettype wire

// ----- sv/cwdm_ctrl.sv -----
// Controller state machine: sequences each slide, the replay, the result and the clears.
`default_nettype none

module cwdm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output cwdm_pkg::t_cmd o_cmd,
    input  cwdm_pkg::t_sts i_sts
);
    import cwdm_pkg::*;

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RED  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_WRX  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;
    localparam logic [2:0] ST_CLR  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_replay;
    logic       n_replay;

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_replay = r_replay;
        o_cmd    = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_sts.init_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_RED;
                end
            end
            ST_RED: begin
                o_cmd.ring_rd = 1'b1;
                o_cmd.replay  = r_replay;
                n_state       = ST_RD;
            end
            ST_RD: begin
                o_cmd.cnt_rd = 1'b1;
                o_cmd.replay = r_replay;
                n_state      = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.upd    = 1'b1;
                o_cmd.replay = r_replay;
                n_state      = ST_WRX;
            end
            ST_WRX: begin
                o_cmd.wrx    = 1'b1;
                o_cmd.replay = r_replay;
                if (r_replay) begin
                    o_cmd.rep_next = 1'b1;
                    if (i_sts.rep_last) begin
                        n_replay = 1'b0;
                        n_state  = ST_EMIT;
                    end else begin
                        n_state = ST_RED;
                    end
                end else if (!i_sts.last) begin
                    n_state = ST_IDLE;
                end else if (i_sts.too_short || i_sts.no_replay) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.rep_init = 1'b1;
                    n_replay       = 1'b1;
                    n_state        = ST_RED;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = ST_CLR;
            end
            ST_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state  = ST_INIT;
                n_replay = 1'b0;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_replay <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_replay <= n_replay;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    // Replay only runs through the slide states
    a_replay_in_slide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_replay |-> (r_state == ST_RED || r_state == ST_RD ||
                      r_state == ST_UPD || r_state == ST_WRX))
        else $error("replay flag outside the slide states");

    // No datapath work while idle
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(o_cmd.upd || o_cmd.wrx || o_cmd.emit || o_cmd.clr_step))
        else $error("datapath command issued while idle");

endmodule

`default_nettype wire

// ----- sv/cwdm_datapath.sv -----
// Datapath: configuration, count table, window ring, head store and score tracking.
`default_nettype none

module cwdm_datapath #(
    parameter int TYPE_COUNT = 4096,
    parameter int MAX_WINDOW = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [cwdm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cwdm_pkg::LEN_W-1:0]         i_cfg_data,
    input  logic [cwdm_pkg::TYPE_W-1:0]        i_type_code,
    input  logic                               i_last_item,
    input  cwdm_pkg::t_cmd                     i_cmd,
    output cwdm_pkg::t_sts                     o_sts,
    output logic                               o_result_valid,
    output logic [cwdm_pkg::SCORE_W-1:0]       o_best_score,
    output logic                               o_too_short
);
    import cwdm_pkg::*;

    localparam int TW = $clog2(TYPE_COUNT);
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SW = $clog2(MAX_WINDOW + 2);

    // Storage
    logic [LW-1:0] cnt_mem  [TYPE_COUNT];
    logic [TW-1:0] ring_mem [MAX_WINDOW];
    logic [TW-1:0] head_mem [MAX_WINDOW];

    // Configuration
    logic [LEN_W-1:0]  r_wlen;
    logic [TYPE_W-1:0] r_bonus;

    // Run control
    logic [LW-1:0] r_run_len;
    logic [LW-1:0] r_seen;
    logic [LW-1:0] r_dist;
    logic [SW-1:0] r_best;
    logic [AW-1:0] r_slot;
    logic [LW-1:0] r_j;
    logic [LW-1:0] r_clr_n;
    logic [LW-1:0] r_k;
    logic          r_cv;
    logic [TW-1:0] r_ik;
    logic          r_ovalid;

    // Item data
    logic [TYPE_W-1:0]  r_x_raw;
    logic               r_last;
    logic [TW-1:0]      r_xm;
    logic [LW-1:0]      r_cx1;
    logic [TW-1:0]      r_ring_q;
    logic [TW-1:0]      r_head_q;
    logic [LW-1:0]      r_cnt_x;
    logic [LW-1:0]      r_cnt_o;
    logic [LW-1:0]      r_cnt_b;
    logic [TW-1:0]      r_bonus_m;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_short;

    // Combinational
    logic [TW-1:0] x_red;
    logic [TW-1:0] bonus_red;
    logic [TW-1:0] x_cur;
    logic [16:0]   wl_ext;
    logic [LW-1:0] n_run_len;
    logic          evict;
    logic          old_dec;
    logic [LW-1:0] old_new;
    logic [LW-1:0] cx;
    logic          gone;
    logic          fresh;
    logic [LW-1:0] n_dist;
    logic [LW-1:0] cx1;
    logic [LW-1:0] n_bcnt;
    logic [SW-1:0] score;
    logic          score_ok;
    logic [SW-1:0] n_best;
    logic [LW-1:0] n_seen;
    logic [LW-1:0] slot_inc;
    logic [AW-1:0] n_slot;
    logic          head_we;
    logic          clr_rd;
    logic          cnt_we;
    logic [TW-1:0] cnt_wa;
    logic [LW-1:0] cnt_wd;
    logic [TW-1:0] cnt_ra;
    logic [AW-1:0] ring_ra;

    // Type code and bonus type taken modulo the type count
    cwdm_modred #(.DIVISOR(TYPE_COUNT)) u_xmod (
        .i_clk   (i_clk),
        .i_value (r_x_raw),
        .o_rem   (x_red)
    );

    cwdm_modred #(.DIVISOR(TYPE_COUNT)) u_bmod (
        .i_clk   (i_clk),
        .i_value (r_bonus),
        .o_rem   (bonus_red)
    );

    // Window length clamped into one to the ring depth
    always_comb begin
        wl_ext = 17'(r_wlen);
        if (r_wlen == '0) begin
            n_run_len = LW'(1);
        end else if (wl_ext > 17'(MAX_WINDOW)) begin
            n_run_len = LW'(MAX_WINDOW);
        end else begin
            n_run_len = LW'(wl_ext);
        end
    end

    // Entering type: fresh item or replayed head item
    assign x_cur = i_cmd.replay ? r_head_q : x_red;

    // Slide update: evict the oldest item, then count the entering one
    always_comb begin
        evict    = (r_seen >= r_run_len);
        old_dec  = evict && (r_cnt_o != '0);
        old_new  = r_cnt_o - LW'(1);
        cx       = (old_dec && (r_xm == r_ring_q)) ? old_new : r_cnt_x;
        gone     = old_dec && (r_cnt_o == LW'(1)) && (r_dist != '0);
        fresh    = (cx == '0);
        n_dist   = r_dist - LW'(gone) + LW'(fresh);
        cx1      = cx + LW'(1);
        if (r_xm == r_bonus_m) begin
            n_bcnt = cx1;
        end else if (old_dec && (r_ring_q == r_bonus_m)) begin
            n_bcnt = old_new;
        end else begin
            n_bcnt = r_cnt_b;
        end
        score    = SW'(n_dist) + SW'(n_bcnt == '0);
        score_ok = (r_seen >= r_run_len - LW'(1));
        n_best   = (score_ok && (score > r_best)) ? score : r_best;
        n_seen   = (r_seen == LW'(MAX_WINDOW)) ? r_seen : r_seen + LW'(1);
        slot_inc = LW'(r_slot) + LW'(1);
        n_slot   = (slot_inc >= r_run_len) ? '0 : AW'(slot_inc);
    end

    // Memory port control
    always_comb begin
        head_we = i_cmd.cnt_rd && !i_cmd.replay && (r_seen < r_run_len - LW'(1));
        clr_rd  = i_cmd.clr_step && (r_k < r_clr_n);
        ring_ra = i_cmd.clr_step ? r_k[AW-1:0] : r_slot;
        // Bonus count is read ahead of the slide while this port is free
        cnt_ra  = i_cmd.cnt_rd ? x_cur : bonus_red;
        cnt_we  = 1'b0;
        cnt_wa  = r_xm;
        cnt_wd  = r_cx1;
        if (i_cmd.init_step) begin
            cnt_we = 1'b1;
            cnt_wa = r_ik;
            cnt_wd = '0;
        end else if (i_cmd.clr_step && r_cv) begin
            cnt_we = 1'b1;
            cnt_wa = r_ring_q;
            cnt_wd = '0;
        end else if (i_cmd.upd && old_dec) begin
            cnt_we = 1'b1;
            cnt_wa = r_ring_q;
            cnt_wd = old_new;
        end else if (i_cmd.wrx) begin
            cnt_we = 1'b1;
        end
    end

    // Count table: one write, two reads, registered read data
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (i_cmd.ring_rd) begin
            r_cnt_b <= cnt_mem[cnt_ra];
        end
        if (i_cmd.cnt_rd) begin
            r_cnt_x <= cnt_mem[cnt_ra];
            r_cnt_o <= cnt_mem[r_ring_q];
        end
    end

    // Window ring
    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_rd) begin
            ring_mem[r_slot] <= x_cur;
        end
        if (i_cmd.ring_rd || clr_rd) begin
            r_ring_q <= ring_mem[ring_ra];
        end
    end

    // Head store
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            head_mem[r_seen[AW-1:0]] <= x_cur;
        end
        if (i_cmd.ring_rd) begin
            r_head_q <= head_mem[r_j[AW-1:0]];
        end
    end

    // Item data registers
    always_ff @(posedge i_clk) begin
        r_bonus_m <= bonus_red;
        if (i_cmd.accept) begin
            r_x_raw <= i_type_code;
            r_last  <= i_last_item;
        end
        if (i_cmd.cnt_rd) begin
            r_xm <= x_cur;
        end
        if (i_cmd.upd) begin
            r_cx1 <= cx1;
        end
        if (i_cmd.emit) begin
            r_out_short <= (r_seen < r_run_len);
            r_out_score <= (r_seen < r_run_len) ? '0 : SCORE_W'(r_best);
        end
    end

    // Configuration and run control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen    <= WINDOW_LEN_RST;
            r_bonus   <= BONUS_TYPE_RST;
            r_run_len <= LW'(1);
            r_seen    <= '0;
            r_dist    <= '0;
            r_best    <= '0;
            r_slot    <= '0;
            r_j       <= '0;
            r_clr_n   <= '0;
            r_k       <= '0;
            r_cv      <= 1'b0;
            r_ik      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_ovalid <= i_cmd.emit;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WINDOW_LEN: r_wlen  <= i_cfg_data;
                    REG_BONUS_TYPE: r_bonus <= i_cfg_data[TYPE_W-1:0];
                    default:        r_wlen  <= r_wlen;
                endcase
            end
            if (i_cmd.accept && (r_seen == '0)) begin
                r_run_len <= n_run_len;
            end
            if (i_cmd.upd) begin
                r_dist <= n_dist;
                r_best <= n_best;
                r_seen <= n_seen;
                r_slot <= n_slot;
            end
            if (i_cmd.rep_init) begin
                r_j <= '0;
            end else if (i_cmd.rep_next) begin
                r_j <= r_j + LW'(1);
            end
            if (i_cmd.init_step) begin
                r_ik <= r_ik + TW'(1);
            end
            // Result taken; arm the clear over the slots the run wrote
            if (i_cmd.emit) begin
                r_clr_n <= (r_seen < r_run_len) ? r_seen : r_run_len;
                r_k     <= '0;
                r_cv    <= 1'b0;
                r_seen  <= '0;
                r_dist  <= '0;
                r_best  <= '0;
                r_slot  <= '0;
            end else if (i_cmd.clr_step) begin
                r_cv <= clr_rd;
                if (clr_rd) begin
                    r_k <= r_k + LW'(1);
                end
            end
        end
    end

    // Status
    always_comb begin
        o_sts.last      = r_last;
        o_sts.too_short = (r_seen < r_run_len);
        o_sts.no_replay = (r_run_len == LW'(1));
        o_sts.rep_last  = (r_j == r_run_len - LW'(2));
        o_sts.clr_done  = (r_k == r_clr_n) && !r_cv;
        o_sts.init_done = (r_ik == TW'(TYPE_COUNT - 1));
    end

    assign o_result_valid = r_ovalid;
    assign o_best_score   = r_out_score;
    assign o_too_short    = r_out_short;

    // Distinct types never outnumber the items seen
    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dist <= r_seen)
        else $error("distinct count above items seen");

    // Ring slot stays inside the latched window
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        LW'(r_slot) < r_run_len)
        else $error("ring slot outside window");

    // A short sequence reports a zero score
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_too_short) |-> (o_best_score == '0))
        else $error("nonzero score on short sequence");

endmodule

`default_nettype wire

// ----- sv/circular_window_distinct_max_top.sv -----
// Top level of the circular window distinct-max block.
`default_nettype none

// Takes a circular sequence of type codes, one item per start, the final item
// flagged by i_last_item, and reports the best window score (distinct types in
// window_len consecutive items, wrapping, plus one when bonus_type is absent).
// An ordinary item keeps busy high through the slide states (ring read, count
// read, update, write-back) before the next start is taken: each slide does a
// read-modify-write of two count entries through the single write port of the
// count table. On the final item the block replays the first window_len-1 items,
// presents the result on o_best_score/o_too_short with o_result_valid high for
// one cycle, then zeroes the count entries of the last window. After reset a
// sweep over all TYPE_COUNT entries clears the count table before the first
// start is taken. Results cannot be held off by the receiver.
// Configuration writes are always ready and must only happen while busy is low.

module circular_window_distinct_max_top #(
    parameter int TYPE_COUNT = 4096,
    parameter int MAX_WINDOW = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [cwdm_pkg::TYPE_W-1:0]        i_type_code,
    input  logic                               i_last_item,
    output logic                               o_result_valid,
    output logic [cwdm_pkg::SCORE_W-1:0]       o_best_score,
    output logic                               o_too_short,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cwdm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cwdm_pkg::LEN_W-1:0]         i_cfg_data
);
    import cwdm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Register writes are always accepted
    assign o_cfg_ready = 1'b1;

    cwdm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    cwdm_datapath #(
        .TYPE_COUNT (TYPE_COUNT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_type_code    (i_type_code),
        .i_last_item    (i_last_item),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_best_score   (o_best_score),
        .o_too_short    (o_too_short)
    );

endmodule

`default_nettype wire

// ----- dv/circular_window_distinct_max_top_tb.sv -----
// Self-checking testbench for the circular window distinct-max block.
module circular_window_distinct_max_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cwdm_pkg::*;

    localparam int TYPE_NUM = 4096;
    localparam int WIN_MAX  = 4096;

    // One emitted result
    typedef struct packed {
        logic [SCORE_W-1:0] best_score;
        logic               too_short;
    } t_score_rec;

    // Tracks every accepted item, predicts the sequence score and checks results
    class t_circular_score_tracker;
        int unsigned     type_count [TYPE_NUM];
        logic [TYPE_W-1:0] ring_type [WIN_MAX];
        logic [TYPE_W-1:0] head_type [WIN_MAX];
        int unsigned     distinct_cnt;
        int unsigned     best_now;
        int unsigned     seen_cnt;
        int unsigned     seq_len;
        int unsigned     ring_pos;
        logic [LEN_W-1:0]  cfg_len;
        logic [TYPE_W-1:0] cfg_bonus;
        t_score_rec      best_score_q[$];
        int              n_items;
        int              n_results;
        int              n_short;
        int              n_errors;

        function new();
            foreach (ring_type[i]) ring_type[i] = '0;
            foreach (head_type[i]) head_type[i] = '0;
            cfg_len   = WINDOW_LEN_RST;
            cfg_bonus = BONUS_TYPE_RST;
            seq_len   = WINDOW_LEN_RST;
            clear_run();
        endfunction

        function void clear_run();
            foreach (type_count[i]) type_count[i] = 0;
            distinct_cnt = 0;
            best_now     = 0;
            seen_cnt     = 0;
            ring_pos     = 0;
        endfunction

        function int unsigned effective_len(logic [LEN_W-1:0] v);
            if (v == 0) return 1;
            if (v > WIN_MAX) return WIN_MAX;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
            if (idx == REG_WINDOW_LEN) cfg_len = data;
            else if (idx == REG_BONUS_TYPE) cfg_bonus = data[TYPE_W-1:0];
        endfunction

        // Advance the window by one entering type; score it once it is full
        function void slide_window(logic [TYPE_W-1:0] x);
            logic [TYPE_W-1:0] gone;
            int unsigned score;
            if (seen_cnt >= seq_len) begin
                gone = ring_type[ring_pos];
                if (type_count[gone] > 0) begin
                    type_count[gone]--;
                    if (type_count[gone] == 0 && distinct_cnt > 0) distinct_cnt--;
                end
            end
            if (type_count[x] == 0) distinct_cnt++;
            type_count[x]++;
            ring_type[ring_pos] = x;
            ring_pos = (ring_pos + 1 >= seq_len) ? 0 : ring_pos + 1;
            if (seen_cnt >= seq_len - 1) begin
                score = distinct_cnt + ((type_count[cfg_bonus] == 0) ? 1 : 0);
                if (score > best_now) best_now = score;
            end
            if (seen_cnt != 32'hFFFF_FFFF) seen_cnt++;
        endfunction

        // Accepted item: update the window and, on the last one, queue the score
        function void note_item(logic [TYPE_W-1:0] tc, logic last);
            t_score_rec rec;
            n_items++;
            if (seen_cnt == 0) begin
                seq_len  = effective_len(cfg_len);
                ring_pos = 0;
            end
            if (seen_cnt < seq_len - 1) head_type[seen_cnt % WIN_MAX] = tc;
            slide_window(tc);
            if (!last) return;
            if (seen_cnt < seq_len) begin
                rec.best_score = '0;
                rec.too_short  = 1'b1;
            end else begin
                for (int unsigned j = 0; j + 1 < seq_len; j++)
                    slide_window(head_type[j % WIN_MAX]);
                rec.best_score = best_now[SCORE_W-1:0];
                rec.too_short  = 1'b0;
            end
            best_score_q = {best_score_q, rec};
            clear_run();
        endfunction

        function int pending();
            return best_score_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            n_errors++;
        endtask

        task check_result(logic [SCORE_W-1:0] score, logic short_flag);
            t_score_rec exp_rec;
            if (best_score_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result score=%0d too_short=%0b",
                                          score, short_flag));
            end else begin
                exp_rec = best_score_q.pop_front();
                n_results++;
                if (exp_rec.too_short) n_short++;
                if (score !== exp_rec.best_score)
                    report_mismatch($sformatf("best_score %0d, expected %0d",
                                              score, exp_rec.best_score));
                if (short_flag !== exp_rec.too_short)
                    report_mismatch($sformatf("too_short %0b, expected %0b",
                                              short_flag, exp_rec.too_short));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_start     = 1'b0;
    logic [TYPE_W-1:0]  i_type_code = '0;
    logic               i_last_item = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LEN_W-1:0]   i_cfg_data  = '0;
    logic               o_busy;
    logic               o_result_valid;
    logic [SCORE_W-1:0] o_best_score;
    logic               o_too_short;
    logic               o_cfg_ready;

    t_circular_score_tracker sb = new();

    // Random type source for the current phase
    int  pool_base;
    int  pool_size;
    bit  no_gaps;
    int  rand_items;

    circular_window_distinct_max_top #(
        .TYPE_COUNT(TYPE_NUM),
        .MAX_WINDOW(WIN_MAX)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_type_code    (i_type_code),
        .i_last_item    (i_last_item),
        .o_result_valid (o_result_valid),
        .o_best_score   (o_best_score),
        .o_too_short    (o_too_short),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Results are sampled at the edge that ends their cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) sb.check_result(o_best_score, o_too_short);
    end

    function int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function logic [TYPE_W-1:0] pick_type();
        if (pool_size >= TYPE_NUM) return TYPE_W'($urandom_range(0, TYPE_NUM - 1));
        return TYPE_W'((pool_base + $urandom_range(0, pool_size - 1)) % TYPE_NUM);
    endfunction

    // Offer one item; start stays high across back-to-back items
    task send_item(logic [TYPE_W-1:0] tc, logic last);
        int gap;
        i_start     <= 1'b1;
        i_type_code <= tc;
        i_last_item <= last;
        do @(posedge i_clk); while (o_busy);
        sb.note_item(tc, last);
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until all scores are in and the block has dropped busy
    task wait_idle();
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (o_busy);
        repeat (2) @(posedge i_clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task configure(logic [LEN_W-1:0] wl, logic [LEN_W-1:0] bonus_data);
        wait_idle();
        write_reg(REG_WINDOW_LEN, wl);
        write_reg(REG_BONUS_TYPE, bonus_data);
    endtask

    initial begin
        int r;
        int wl;
        int eff;
        int len;
        int nseq;
        logic [LEN_W-1:0] bonus_data;

        no_gaps    = 1'b0;
        pool_base  = 0;
        pool_size  = TYPE_NUM;
        rand_items = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: window of four, bonus type one
        send_item(12'd1, 1'b0);
        send_item(12'd1, 1'b0);
        send_item(12'd1, 1'b0);
        send_item(12'd1, 1'b1);
        send_item(12'd0, 1'b0);
        send_item(12'd4095, 1'b0);
        send_item(12'd0, 1'b0);
        send_item(12'd4095, 1'b0);
        send_item(12'hAAA, 1'b0);
        send_item(12'h555, 1'b1);
        // Single item, shorter than the window
        send_item(12'd5, 1'b1);

        // Zero length acts as one; bonus data with the unused top bit set
        configure(13'd0, 13'h1FFF);
        send_item(12'd4095, 1'b0);
        send_item(12'd0, 1'b1);

        // Oversized length clamps to the maximum window, sequence too short
        configure(13'h1FFF, 13'd0);
        send_item(12'd0, 1'b0);
        send_item(12'd1, 1'b0);
        send_item(12'd2, 1'b1);

        // Length rewritten mid-sequence only applies to the next sequence
        configure(13'd2, 13'd8);
        send_item(12'd7, 1'b0);
        send_item(12'd8, 1'b0);
        wait_idle();
        write_reg(REG_WINDOW_LEN, 13'd3);
        send_item(12'd9, 1'b1);
        send_item(12'd4095, 1'b0);
        send_item(12'd4095, 1'b0);
        send_item(12'd0, 1'b1);

        // Long window with one wrapped sequence, type pool wrapping past the top code
        configure(13'd256, 13'h0FFF);
        pool_size = 200;
        pool_base = 3950;
        for (int k = 0; k <= 256; k++) send_item(pick_type(), k == 256);

        // Random phases of several sequences each
        while (rand_items < 800) begin
            r = $urandom_range(0, 99);
            if (r < 35) wl = $urandom_range(1, 4);
            else if (r < 80) wl = $urandom_range(5, 16);
            else if (r < 95) wl = $urandom_range(17, 64);
            else if (r < 97) wl = 0;
            else wl = $urandom_range(4097, 8191);
            bonus_data = LEN_W'($urandom_range(0, 8191));
            configure(LEN_W'(wl), bonus_data);
            eff = (wl == 0) ? 1 : ((wl > WIN_MAX) ? WIN_MAX : wl);
            pool_base = (bonus_data[TYPE_W-1:0] + TYPE_NUM - $urandom_range(0, 3)) % TYPE_NUM;
            pool_size = ($urandom_range(0, 4) == 0) ? TYPE_NUM : $urandom_range(1, eff + 3);
            nseq = $urandom_range(2, 5);
            repeat (nseq) begin
                if (eff == WIN_MAX) len = $urandom_range(1, 6);
                else if (eff > 1 && $urandom_range(0, 9) == 0) len = $urandom_range(1, eff - 1);
                else len = $urandom_range(eff, 3 * eff + 4);
                no_gaps = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < len; k++) send_item(pick_type(), k == len - 1);
                rand_items += len;
            end
        end

        // Drain: last score, then the clear pass
        wait_idle();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d items in %0d sequences, %0d of them too short.",
                 sb.n_items, sb.n_results, sb.n_short);
        $display("Window lengths from zero to the clamp limit, %0d mismatches.",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("Timeout waiting on the block");
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- circular_window_distinct_max_top.f -----
sv/cwdm_pkg.sv
sv/cwdm_modred.sv
sv/cwdm_ctrl.sv
sv/cwdm_datapath.sv
sv/circular_window_distinct_max_top.sv
dv/circular_window_distinct_max_top_tb.sv
